>>> rtl/core/assert_macros.svh
// Assertion macros for the regulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication or plain property, checked on every rising clock edge outside reset.
`define ASSERT_CHK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");

// Condition in this cycle implies an expectation in the next cycle.
`define ASSERT_NEXT(label, clock, reset, cond, conseq) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
    else $error("assertion failed");

`else

`define ASSERT_CHK(label, clock, reset, prop)
`define ASSERT_NEXT(label, clock, reset, cond, conseq)

`endif

`endif

>>> rtl/core/phvr_pkg.sv
// Types, constants and register codes for the predictive hysteresis valve regulator.
package phvr_pkg;

  localparam int LEVEL_BITS     = 13;
  localparam int SUM_BITS       = 16;
  localparam int TICK_BITS      = 16;
  localparam int HYST_BITS      = 9;
  localparam int SHIFT_BITS     = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_TDATA_BITS = 16;
  localparam int ACTION_BITS    = 2;

  localparam int READING_BITS_DEFAULT = 13;

  localparam logic [LEVEL_BITS-1:0] TARGET_RESET   = 13'd5800;
  localparam logic [HYST_BITS-1:0]  HYST_RESET     = 9'd50;
  localparam logic [TICK_BITS-1:0]  RESPONSE_RESET = 16'd120;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET    = 3'd2;

  // eight times the target reset, modulo 2^16
  localparam logic [SUM_BITS-1:0] SUM_RESET =
    SUM_BITS'({{(SUM_BITS-LEVEL_BITS){1'b0}}, TARGET_RESET} << 3);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TARGET_LEVEL    = 2'd0,
    REG_HYSTERESIS      = 2'd1,
    REG_RESPONSE_TICKS  = 2'd2,
    REG_STEEPNESS_SHIFT = 2'd3
  } reg_index_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_HOLD  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_OPEN  = 2'd2
  } action_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] target_level;
    logic [HYST_BITS-1:0]  hysteresis;
    logic [TICK_BITS-1:0]  response_ticks;
    logic [SHIFT_BITS-1:0] steepness_shift;
  } cfg_t;

endpackage

>>> rtl/core/predictive_hysteresis_valve_regulator.sv
// Top level of the predictive hysteresis valve regulator.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: raw_reading
//  m_*      | out       | m_tvalid/m_tready  | tdata: smoothed_level, valve_action; tuser: decided
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction in gives one transaction out. The path runs through an input
// register, then a single pass of running-sum, tick and extrapolation logic into
// the result register. One item per clock is sustained while m_tready holds; the
// running-sum update feeding the next item's average sets that figure.
// Synchronous reset loads the register reset values and the sum at eight times the
// target. A stalled output holds its result while one more item waits in the
// input register; s_tready drops only when both are full.
`include "assert_macros.svh"

module predictive_hysteresis_valve_regulator #(
  parameter int READING_BITS = phvr_pkg::READING_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [phvr_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [12:0] raw_reading
  // master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [phvr_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [12:0] smoothed_level, [14:13] valve_action
  output logic                                m_tuser,   // [0] decided
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [phvr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [phvr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int OUT_PAD = phvr_pkg::OUT_TDATA_BITS - phvr_pkg::LEVEL_BITS
                           - phvr_pkg::ACTION_BITS;

  phvr_pkg::cfg_t cfg;

  // input register
  logic                    in_valid;
  logic [READING_BITS-1:0] in_reading;

  // running state
  logic [phvr_pkg::SUM_BITS-1:0]   scaled_sum;
  logic [phvr_pkg::LEVEL_BITS-1:0] average_level;
  logic [phvr_pkg::TICK_BITS-1:0]  tick_count;
  logic [phvr_pkg::LEVEL_BITS-1:0] last_level;
  phvr_pkg::action_t               held_action;

  // result register
  logic [phvr_pkg::LEVEL_BITS-1:0] out_level;
  logic                            out_decided;
  phvr_pkg::action_t               out_action;

  logic                            take_in;
  logic                            advance;
  logic [phvr_pkg::SUM_BITS-1:0]   sum_next;
  logic [phvr_pkg::LEVEL_BITS-1:0] avg_next;
  logic [phvr_pkg::TICK_BITS-1:0]  tick_inc;
  logic                            decide;
  phvr_pkg::action_t               new_action;

  phvr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: the result register frees when taken, the input register when it moves on
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign take_in  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // narrow readings keep only their low bits
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_reading <= s_tdata[READING_BITS-1:0];
    end
  end

  // running sum drops the old average and gains the reading; average is sum / 8
  assign sum_next = scaled_sum - phvr_pkg::SUM_BITS'(average_level)
                    + phvr_pkg::SUM_BITS'(in_reading);
  assign avg_next = sum_next[phvr_pkg::SUM_BITS-1:phvr_pkg::SUM_BITS-phvr_pkg::LEVEL_BITS];

  // counter wraps at 2^16, so a maximum response time never lets a decision through
  assign tick_inc = tick_count + 1'b1;
  assign decide   = tick_inc > cfg.response_ticks;

  phvr_predict u_predict (
    .average_level (avg_next),
    .last_level    (last_level),
    .cfg           (cfg),
    .action        (new_action)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_sum    <= phvr_pkg::SUM_RESET;
      average_level <= '0;
      tick_count    <= '0;
      last_level    <= '0;
      held_action   <= phvr_pkg::ACT_HOLD;
    end else if (advance) begin
      scaled_sum    <= sum_next;
      average_level <= avg_next;
      if (decide) begin
        tick_count  <= '0;
        last_level  <= avg_next;
        held_action <= new_action;
      end else begin
        tick_count  <= tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // without a decision the result repeats the held action
  always_ff @(posedge clk) begin
    if (advance) begin
      out_level   <= avg_next;
      out_decided <= decide;
      out_action  <= decide ? new_action : held_action;
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_action, out_level};
  assign m_tuser = out_decided;

  `ASSERT_NEXT(a_decide_resets, clk, rst, advance && decide, tick_count == '0 && last_level == $past(avg_next))
  `ASSERT_NEXT(a_action_held, clk, rst, advance && !decide, held_action == $past(held_action))
  `ASSERT_CHK(a_stall_cause, clk, rst, !s_tready |-> (in_valid && m_tvalid && !m_tready))
  `ASSERT_NEXT(a_result_tracks, clk, rst, advance, out_action == held_action && out_level == average_level)

endmodule

>>> rtl/core/phvr_cfg.sv
// Configuration register bank of the regulator.
module phvr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [phvr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [phvr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output phvr_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level    <= phvr_pkg::TARGET_RESET;
      cfg.hysteresis      <= phvr_pkg::HYST_RESET;
      cfg.response_ticks  <= phvr_pkg::RESPONSE_RESET;
      cfg.steepness_shift <= phvr_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (phvr_pkg::reg_index_t'(cfg_index))
        phvr_pkg::REG_TARGET_LEVEL: begin
          cfg.target_level <= cfg_data[phvr_pkg::LEVEL_BITS-1:0];
        end
        phvr_pkg::REG_HYSTERESIS: begin
          cfg.hysteresis <= cfg_data[phvr_pkg::HYST_BITS-1:0];
        end
        phvr_pkg::REG_RESPONSE_TICKS: begin
          cfg.response_ticks <= cfg_data[phvr_pkg::TICK_BITS-1:0];
        end
        phvr_pkg::REG_STEEPNESS_SHIFT: begin
          cfg.steepness_shift <= cfg_data[phvr_pkg::SHIFT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/phvr_predict.sv
// Trend extrapolation and corridor compare that picks the valve action.
module phvr_predict (
  input  logic [phvr_pkg::LEVEL_BITS-1:0] average_level,
  input  logic [phvr_pkg::LEVEL_BITS-1:0] last_level,
  input  phvr_pkg::cfg_t                  cfg,
  output phvr_pkg::action_t               action
);

  localparam int EXT_BITS = phvr_pkg::SUM_BITS - phvr_pkg::LEVEL_BITS;

  logic [phvr_pkg::SUM_BITS-1:0]   avg_ext;
  logic [phvr_pkg::SUM_BITS-1:0]   diff;
  logic [phvr_pkg::SUM_BITS-1:0]   slope;
  logic [phvr_pkg::SUM_BITS-1:0]   future;
  logic [phvr_pkg::SUM_BITS-1:0]   upper;
  logic [phvr_pkg::LEVEL_BITS-1:0] hyst_ext;
  logic [phvr_pkg::LEVEL_BITS-1:0] lower;
  logic                            lower_ok;
  logic                            below;
  logic                            above;

  assign avg_ext = {{EXT_BITS{1'b0}}, average_level};
  assign diff    = avg_ext - {{EXT_BITS{1'b0}}, last_level};
  assign slope   = diff << cfg.steepness_shift;
  assign future  = avg_ext + slope;

  assign hyst_ext = {{(phvr_pkg::LEVEL_BITS-phvr_pkg::HYST_BITS){1'b0}}, cfg.hysteresis};
  assign upper    = {{EXT_BITS{1'b0}}, cfg.target_level} +
                    {{(phvr_pkg::SUM_BITS-phvr_pkg::HYST_BITS){1'b0}}, cfg.hysteresis};
  // lower bound under zero: close is never chosen
  assign lower_ok = hyst_ext <= cfg.target_level;
  assign lower    = cfg.target_level - hyst_ext;

  assign below = lower_ok && (future < {{EXT_BITS{1'b0}}, lower});
  assign above = future > upper;

  always_comb begin
    if (below) begin
      action = phvr_pkg::ACT_CLOSE;
    end else if (above) begin
      action = phvr_pkg::ACT_OPEN;
    end else begin
      action = phvr_pkg::ACT_HOLD;
    end
  end

endmodule
